// ===== rtl/dvr_pkg.sv =====
package dvr_pkg;

   // fixed field widths of the request and response ports
   localparam int NODE_W      = 4;
   localparam int DIST_PORT_W = 16;

   // defaults for the top level parameters
   localparam int NODE_COUNT_DEFAULT = 16;
   localparam int DIST_WIDTH_DEFAULT = 16;

   // request operation codes
   localparam logic OP_LOAD     = 1'b0;
   localparam logic OP_NEIGHBOR = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;   // latch request, launch table reads
      logic commit;    // write table, load response register
   } cmd_type;

endpackage

// ===== rtl/dvr_ctrl.sv =====
module dvr_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output dvr_pkg::cmd_type cmd
);
   import dvr_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      req_stall   = 1'b1;
      out_free    = !rsp_valid_ff || !rsp_stall;
      // a taken response drops unless a new one loads
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/dvr_datapath.sv =====
module dvr_datapath #(
   parameter int NODE_COUNT = dvr_pkg::NODE_COUNT_DEFAULT,
   parameter int DIST_WIDTH = dvr_pkg::DIST_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  dvr_pkg::cmd_type                 cmd,
   input  logic                             req_operation,
   input  logic [dvr_pkg::NODE_W-1:0]       req_sender,
   input  logic [dvr_pkg::NODE_W-1:0]       req_destination,
   input  logic [dvr_pkg::DIST_PORT_W-1:0]  req_distance,
   output logic [dvr_pkg::NODE_W-1:0]       rsp_route_destination,
   output logic [dvr_pkg::DIST_PORT_W-1:0]  rsp_route_distance,
   output logic [dvr_pkg::NODE_W-1:0]       rsp_route_next_hop,
   output logic                             rsp_route_valid,
   output logic                             rsp_route_changed,
   output logic                             rsp_sender_unknown
);
   import dvr_pkg::*;

   localparam int IDX_W = $clog2(NODE_COUNT);
   localparam int EXT_W = (IDX_W > NODE_W) ? IDX_W : NODE_W;
   localparam logic [DIST_WIDTH-1:0] DIST_MAX = {DIST_WIDTH{1'b1}};

   // route table memory, two read ports, one write port
   logic [DIST_WIDTH-1:0] dist_mem [NODE_COUNT];
   logic [NODE_W-1:0]     hop_mem  [NODE_COUNT];
   logic                  valid_ff [NODE_COUNT];

   logic                  op_ff;
   logic [NODE_W-1:0]     snd_ff, dest_ff;
   logic [DIST_WIDTH-1:0] dist_ff;
   logic [DIST_WIDTH-1:0] snd_dist_ff, dst_dist_ff;
   logic [NODE_W-1:0]     dst_hop_ff;

   logic [EXT_W-1:0] req_snd_ext, req_dst_ext, snd_ext, dst_ext;
   logic [IDX_W-1:0] req_snd_idx, req_dst_idx, snd_idx, dst_idx;

   logic                  snd_ok, dst_ok, snd_valid, dst_valid;
   logic [DIST_WIDTH:0]   sum;
   logic [DIST_WIDTH-1:0] cand, new_dist, out_dist;
   logic [NODE_W-1:0]     new_hop, out_hop;
   logic                  wr_en, changed, unknown, present;

   assign req_snd_ext = EXT_W'(req_sender);
   assign req_dst_ext = EXT_W'(req_destination);
   assign req_snd_idx = req_snd_ext[IDX_W-1:0];
   assign req_dst_idx = req_dst_ext[IDX_W-1:0];
   assign snd_ext     = EXT_W'(snd_ff);
   assign dst_ext     = EXT_W'(dest_ff);
   assign snd_idx     = snd_ext[IDX_W-1:0];
   assign dst_idx     = dst_ext[IDX_W-1:0];

   // request capture and registered table reads
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= req_operation;
         snd_ff      <= req_sender;
         dest_ff     <= req_destination;
         dist_ff     <= DIST_WIDTH'(req_distance);
         snd_dist_ff <= dist_mem[req_snd_idx];
         dst_dist_ff <= dist_mem[req_dst_idx];
         dst_hop_ff  <= hop_mem[req_dst_idx];
      end
   end

   always_comb begin
      snd_ok    = 32'(snd_ff) < 32'(NODE_COUNT);
      dst_ok    = 32'(dest_ff) < 32'(NODE_COUNT);
      snd_valid = snd_ok && valid_ff[snd_idx];
      dst_valid = dst_ok && valid_ff[dst_idx];

      // saturating candidate through the sender
      sum  = {1'b0, dist_ff} + {1'b0, snd_dist_ff};
      cand = sum[DIST_WIDTH] ? DIST_MAX : sum[DIST_WIDTH-1:0];

      if (op_ff == OP_LOAD) begin
         unknown  = 1'b0;
         new_dist = dist_ff;
         new_hop  = dest_ff;
         wr_en    = dst_ok;
         changed  = dst_ok && (!dst_valid || dst_dist_ff != dist_ff ||
                               dst_hop_ff != dest_ff);
      end else begin
         unknown  = !snd_valid;
         new_dist = cand;
         new_hop  = snd_ff;
         wr_en    = snd_valid && dst_ok && (!dst_valid || cand < dst_dist_ff);
         changed  = wr_en;
      end

      present  = dst_valid || wr_en;
      out_dist = !present ? '0 : (wr_en ? new_dist : dst_dist_ff);
      out_hop  = !present ? '0 : (wr_en ? new_hop : dst_hop_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && wr_en) begin
         dist_mem[dst_idx] <= new_dist;
         hop_mem[dst_idx]  <= new_hop;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NODE_COUNT; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (cmd.commit && wr_en) begin
         valid_ff[dst_idx] <= 1'b1;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_route_destination <= dest_ff;
         rsp_route_distance    <= DIST_PORT_W'(out_dist);
         rsp_route_next_hop    <= out_hop;
         rsp_route_valid       <= present;
         rsp_route_changed     <= changed;
         rsp_sender_unknown    <= unknown;
      end
   end

endmodule

// ===== rtl/distance_vector_route_update_unit.sv =====
// distance-vector route table indexed by destination. a load request installs a
// direct link cost (next hop is the destination itself); a neighbor request
// relaxes the destination through the sender with a saturating add and takes the
// new route only if it is absent or strictly shorter. every request returns one
// response with the resulting entry, a changed flag and a flag for a sender with
// no local route (request ignored). one request is in flight at a time: the table
// memory is read into registers as the request is taken, then the compare and
// write back follow once the response register is free, after any wait on
// rsp_stall while it is still full. valid bits are cleared by reset at once, so
// no clearing pass is needed
module distance_vector_route_update_unit #(
   parameter int NODE_COUNT = dvr_pkg::NODE_COUNT_DEFAULT,
   parameter int DIST_WIDTH = dvr_pkg::DIST_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_operation,
   input  logic [dvr_pkg::NODE_W-1:0]       req_sender,
   input  logic [dvr_pkg::NODE_W-1:0]       req_destination,
   input  logic [dvr_pkg::DIST_PORT_W-1:0]  req_distance,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [dvr_pkg::NODE_W-1:0]       rsp_route_destination,
   output logic [dvr_pkg::DIST_PORT_W-1:0]  rsp_route_distance,
   output logic [dvr_pkg::NODE_W-1:0]       rsp_route_next_hop,
   output logic                             rsp_route_valid,
   output logic                             rsp_route_changed,
   output logic                             rsp_sender_unknown
);
   import dvr_pkg::*;

   // capture and commit strobes from the controller
   cmd_type cmd;

   // sequencer: accepts a request, then commits it once the response slot frees
   dvr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // table memory, valid bits, relaxation logic and response register
   dvr_datapath #(
      .NODE_COUNT (NODE_COUNT),
      .DIST_WIDTH (DIST_WIDTH)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .req_operation         (req_operation),
      .req_sender            (req_sender),
      .req_destination       (req_destination),
      .req_distance          (req_distance),
      .rsp_route_destination (rsp_route_destination),
      .rsp_route_distance    (rsp_route_distance),
      .rsp_route_next_hop    (rsp_route_next_hop),
      .rsp_route_valid       (rsp_route_valid),
      .rsp_route_changed     (rsp_route_changed),
      .rsp_sender_unknown    (rsp_sender_unknown)
   );

endmodule

// ===== bench/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import dvr_pkg::*;

   // block configuration as built, defaults of the top level
   localparam int NODES  = NODE_COUNT_DEFAULT;
   localparam int DIST_W = DIST_WIDTH_DEFAULT;
   localparam logic [DIST_PORT_W-1:0] DIST_CAP = DIST_PORT_W'((64'd1 << DIST_W) - 1);

   localparam int RANDOM_REQUESTS = 800;
   localparam int PHASE_ONE_END   = 300;   // sender idles lightly, receiver heavily
   localparam int PHASE_TWO_END   = 560;   // roles swapped, then nobody idles
   localparam int LONG_HOLD_AT    = 650;   // receiver blocks here while sender streams
   localparam int LONG_HOLD_LEN   = 60;
   localparam int WATCHDOG_LIMIT  = 2000;

   typedef struct {
      logic                   op;
      logic [NODE_W-1:0]      sender;
      logic [NODE_W-1:0]      destination;
      logic [DIST_PORT_W-1:0] distance;
      bit                     drain;   // sender waits for all responses first
   } route_req_type;

   typedef struct {
      logic [NODE_W-1:0]      destination;
      logic [DIST_PORT_W-1:0] distance;
      logic [NODE_W-1:0]      next_hop;
      logic                   valid;
      logic                   changed;
      logic                   sender_unknown;
   } route_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid       = 1'b0;
   logic                   req_stall;
   logic                   req_operation   = OP_LOAD;
   logic [NODE_W-1:0]      req_sender      = '0;
   logic [NODE_W-1:0]      req_destination = '0;
   logic [DIST_PORT_W-1:0] req_distance    = '0;

   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [NODE_W-1:0]      rsp_route_destination;
   logic [DIST_PORT_W-1:0] rsp_route_distance;
   logic [NODE_W-1:0]      rsp_route_next_hop;
   logic                   rsp_route_valid;
   logic                   rsp_route_changed;
   logic                   rsp_sender_unknown;

   distance_vector_route_update_unit u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_operation         (req_operation),
      .req_sender            (req_sender),
      .req_destination       (req_destination),
      .req_distance          (req_distance),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_route_destination (rsp_route_destination),
      .rsp_route_distance    (rsp_route_distance),
      .rsp_route_next_hop    (rsp_route_next_hop),
      .rsp_route_valid       (rsp_route_valid),
      .rsp_route_changed     (rsp_route_changed),
      .rsp_sender_unknown    (rsp_sender_unknown)
   );

   always #2 clock = ~clock;

   // requests waiting to be offered, and responses the route table should give
   route_req_type pending_requests[$];
   route_rsp_type awaited_routes[$];
   route_req_type current_req;

   // shadow route table of the block
   bit                     known_route[NODES];
   logic [DIST_PORT_W-1:0] route_cost[NODES];
   logic [NODE_W-1:0]      route_exit[NODES];

   // valid bits as seen while building the stimulus, to pick live senders
   bit planned_known[NODES];
   bit drain_next;

   int unsigned requests_sent  = 0;
   int unsigned routes_checked = 0;
   int unsigned mismatches     = 0;
   int unsigned idle_cycles    = 0;
   int unsigned hold_left      = 0;
   bit          hold_done      = 1'b0;

   task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
      $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
      mismatches++;
   endtask

   // one bellman-ford relaxation step on the shadow table
   function automatic route_rsp_type relax_route(route_req_type r);
      route_rsp_type          o;
      logic [DIST_PORT_W:0]   sum;
      logic [DIST_PORT_W-1:0] cand;
      logic [DIST_PORT_W-1:0] cost;
      int                     d;
      int                     s;
      d = int'(r.destination);
      s = int'(r.sender);
      cost = r.distance & DIST_CAP;
      o.changed = 1'b0;
      o.sender_unknown = 1'b0;
      if (r.op == OP_LOAD) begin
         if (d < NODES) begin
            o.changed = !known_route[d] || route_cost[d] != cost ||
                        route_exit[d] != r.destination;
            known_route[d] = 1'b1;
            route_cost[d]  = cost;
            route_exit[d]  = r.destination;
         end
      end else if (s >= NODES || !known_route[s]) begin
         // no route to the sender, request dropped
         o.sender_unknown = 1'b1;
      end else begin
         sum  = {1'b0, cost} + {1'b0, route_cost[s]};
         cand = (sum > {1'b0, DIST_CAP}) ? DIST_CAP : sum[DIST_PORT_W-1:0];
         if (d < NODES && (!known_route[d] || cand < route_cost[d])) begin
            known_route[d] = 1'b1;
            route_cost[d]  = cand;
            route_exit[d]  = r.sender;
            o.changed      = 1'b1;
         end
      end
      o.destination = r.destination;
      o.valid       = (d < NODES) && known_route[d];
      o.distance    = o.valid ? route_cost[d] : '0;
      o.next_hop    = o.valid ? route_exit[d] : '0;
      return o;
   endfunction

   task automatic add_request(logic op, int s, int d, logic [DIST_PORT_W-1:0] cost);
      route_req_type r;
      r.op          = op;
      r.sender      = NODE_W'(s);
      r.destination = NODE_W'(d);
      r.distance    = cost;
      r.drain       = drain_next;
      drain_next    = 1'b0;
      pending_requests = {pending_requests, r};
      if (op == OP_LOAD || planned_known[r.sender])
         planned_known[r.destination] = 1'b1;
   endtask

   // extremes often, small costs so relaxations win, full range for bit coverage
   function automatic logic [DIST_PORT_W-1:0] pick_distance();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 8)
         return '0;
      else if (roll < 16)
         return '1;
      else if (roll < 60)
         return DIST_PORT_W'($urandom_range(63));
      else
         return DIST_PORT_W'($urandom);
   endfunction

   function automatic int sender_idle_pct(int unsigned n);
      if (n < PHASE_ONE_END)
         return 36;
      else if (n < PHASE_TWO_END)
         return 83;
      return 0;
   endfunction

   function automatic int receiver_idle_pct(int unsigned n);
      if (n < PHASE_ONE_END)
         return 83;
      else if (n < PHASE_TWO_END)
         return 36;
      return 0;
   endfunction

   // stimulus, then wait for the table to drain and judge
   initial begin
      int unsigned roll;
      int          live[$];
      drain_next = 1'b0;
      foreach (known_route[i]) begin
         known_route[i]   = 1'b0;
         planned_known[i] = 1'b0;
      end

      // directed part
      add_request(OP_NEIGHBOR, 3, 5, 16'd9);        // empty table, sender unknown
      add_request(OP_LOAD, 0, 0, 16'd0);            // zero cost link
      add_request(OP_LOAD, 0, 15, 16'hFFFF);        // largest cost, top node
      add_request(OP_LOAD, 7, 3, 16'd10);
      add_request(OP_LOAD, 0, 3, 16'd10);           // same load again, no change
      add_request(OP_LOAD, 0, 3, 16'd7);            // lower cost reload
      add_request(OP_NEIGHBOR, 3, 7, 16'd5);        // absent destination added
      add_request(OP_NEIGHBOR, 3, 7, 16'd5);        // equal candidate, no change
      add_request(OP_NEIGHBOR, 3, 7, 16'd4);        // strictly shorter, taken
      add_request(OP_NEIGHBOR, 15, 8, 16'hFFFF);    // sum saturates
      add_request(OP_NEIGHBOR, 15, 8, 16'd1);       // saturated equal, no change
      add_request(OP_NEIGHBOR, 0, 8, 16'd100);      // improves saturated route
      add_request(OP_NEIGHBOR, 3, 3, 16'd0);        // self relax, equal
      add_request(OP_LOAD, 15, 7, 16'd20);          // load over a learned route
      add_request(OP_LOAD, 15, 7, 16'd20);          // same load again, no change
      add_request(OP_NEIGHBOR, 9, 0, 16'd1);        // unknown sender on a live entry
      add_request(OP_NEIGHBOR, 0, 12, 16'd0);       // zero sum added
      add_request(OP_LOAD, 0, 8, 16'd100);          // same cost, other next hop
      add_request(OP_NEIGHBOR, 15, 15, 16'hFFFF);   // all ones fields

      // random part, mostly relaxations through live senders
      drain_next = 1'b1;
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         if (i == 430)
            drain_next = 1'b1;
         roll = $urandom_range(99);
         live = {};
         foreach (planned_known[n])
            if (planned_known[n])
               live = {live, n};
         if (roll < 30 || live.size() == 0)
            add_request(OP_LOAD, $urandom, $urandom, pick_distance());
         else if (roll < 90)
            add_request(OP_NEIGHBOR, live[$urandom_range(live.size() - 1)], $urandom,
                        pick_distance());
         else
            add_request(OP_NEIGHBOR, $urandom, $urandom, pick_distance());
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_valid || routes_checked != requests_sent)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (awaited_routes.size() != 0)
         flag_mismatch("responses never returned", 0, awaited_routes.size());
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // request driver: predicts at acceptance, offers next request or idles
   always @(posedge clock) begin
      route_req_type nxt;
      bit            holding;
      int unsigned   outstanding;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         holding     = req_valid;
         outstanding = requests_sent - routes_checked;
         if (req_valid && !req_stall) begin
            awaited_routes = {awaited_routes, relax_route(current_req)};
            requests_sent <= requests_sent + 1;
            holding = 1'b0;
            outstanding++;
         end
         // a stalled request keeps its payload and valid untouched
         if (!holding) begin
            if (pending_requests.size() != 0
                && !(pending_requests[0].drain && outstanding != 0)
                && $urandom_range(99) >= sender_idle_pct(requests_sent)) begin
               nxt = pending_requests.pop_front();
               current_req     = nxt;
               req_valid       <= 1'b1;
               req_operation   <= nxt.op;
               req_sender      <= nxt.sender;
               req_destination <= nxt.destination;
               req_distance    <= nxt.distance;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor: checks against the oldest prediction, drives stall
   always @(posedge clock) begin
      route_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            routes_checked <= routes_checked + 1;
            if (awaited_routes.size() == 0) begin
               flag_mismatch("response with nothing pending", rsp_route_destination, 0);
            end else begin
               want = awaited_routes.pop_front();
               if (rsp_route_destination !== want.destination)
                  flag_mismatch("route_destination", rsp_route_destination, want.destination);
               if (rsp_route_distance !== want.distance)
                  flag_mismatch("route_distance", rsp_route_distance, want.distance);
               if (rsp_route_next_hop !== want.next_hop)
                  flag_mismatch("route_next_hop", rsp_route_next_hop, want.next_hop);
               if (rsp_route_valid !== want.valid)
                  flag_mismatch("route_valid", rsp_route_valid, want.valid);
               if (rsp_route_changed !== want.changed)
                  flag_mismatch("route_changed", rsp_route_changed, want.changed);
               if (rsp_sender_unknown !== want.sender_unknown)
                  flag_mismatch("sender_unknown", rsp_sender_unknown, want.sender_unknown);
            end
         end
         // one long block on the response side so the unit backs up its input
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (!hold_done && requests_sent >= LONG_HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD_LEN;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_idle_pct(routes_checked));
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
